// File: rtl/block_decomposed_range_add_sum_top_defines.svh
// Assertion macros for the range add / range sum block checker.
// Used by the checker module only; needs aclk and aresetn in scope.
`ifndef BLOCK_DECOMPOSED_RANGE_ADD_SUM_TOP_DEFINES_SVH
`define BLOCK_DECOMPOSED_RANGE_ADD_SUM_TOP_DEFINES_SVH

// Same-cycle implication, off while in reset
`define BRDRAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset
`define BRDRAS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset as well
`define BRDRAS_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/brdras_pkg.sv
// Shared constants, request codes and control structs for the range add / range sum block.
// No dependencies.
package brdras_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int BLOCK_SIZE   = 32;
    localparam int NUM_BLOCKS   = MAX_ELEMENTS / BLOCK_SIZE;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int BLOCK_SHIFT  = $clog2(BLOCK_SIZE);
    localparam int BLK_W        = ADDR_W - BLOCK_SHIFT;
    localparam int IDX_W        = 11;
    localparam int DATA_W       = 64;
    localparam int TYPE_W       = 2;
    localparam int S_TDATA_W    = 88;
    localparam logic [IDX_W-1:0] CNT_RESET = IDX_W'(1024);

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD  = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_BAD   = 2'd3
    } req_type_t;

    typedef struct packed {
        logic capture;
        logic issue;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic bad;
        logic walk_done;
    } dp_stat_t;

endpackage

// File: rtl/brdras_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module brdras_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/brdras_ctrl.sv
// Controller state machine for the range add / range sum block.
// Depends on brdras_pkg; drives the datapath through dp_cmd_t.
module brdras_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output brdras_pkg::dp_cmd_t  cmd,
    input  brdras_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = stat.bad ? ST_FINISH : ST_WALK;
            end
            ST_WALK: begin
                cmd.issue = 1'b1;
                if (stat.walk_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/brdras_dp.sv
// Datapath: request registers, range walker, element RAM, block sums and pending adds.
// Depends on brdras_pkg and brdras_ram; controlled by brdras_ctrl.
module brdras_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [brdras_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [brdras_pkg::TYPE_W-1:0]       s_tuser,
    input  logic                                cfg_valid,
    input  logic [brdras_pkg::IDX_W-1:0]        cfg_data,
    output logic [brdras_pkg::DATA_W-1:0]       m_tdata,
    output logic                                m_tuser,
    input  brdras_pkg::dp_cmd_t                 cmd,
    output brdras_pkg::dp_stat_t                stat
);

    localparam int IW = brdras_pkg::IDX_W;
    localparam int DW = brdras_pkg::DATA_W;
    localparam int AW = brdras_pkg::ADDR_W;
    localparam int BW = brdras_pkg::BLK_W;
    localparam int NB = brdras_pkg::NUM_BLOCKS;
    localparam int SH = brdras_pkg::BLOCK_SHIFT;

    logic [IW-1:0]             cnt_reg;
    brdras_pkg::req_type_t     type_reg;
    logic [IW-1:0]             x_reg, y_reg, idx_reg, idx_next;
    logic [DW-1:0]             v_reg;
    logic [DW-1:0]             acc_reg, acc_next;
    logic [DW-1:0]             out_sum_reg;
    logic                      out_stat_reg;
    logic [DW-1:0]             sum_reg [NB];
    logic [DW-1:0]             pend_reg [NB];
    logic                      s1_valid_reg, s1_whole_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic [BW-1:0]             s1_blk_reg;
    logic [IW-1:0]             lim;
    logic [IW-1:0]             idx_m1, x_m1, y_m1;
    logic [BW-1:0]             cur_blk, bx, by;
    logic                      whole, bad;
    logic [DW-1:0]             rd_data, wr_data, blk_sum, blk_pend;
    logic [DW-1:0]             sum_new, pend_new;
    logic                      ram_we, sum_we, pend_we;

    // Limit is the smaller of the element count and the array size
    assign lim = (cnt_reg > IW'(brdras_pkg::MAX_ELEMENTS)) ?
                 IW'(brdras_pkg::MAX_ELEMENTS) : cnt_reg;

    // Request check
    always_comb begin
        case (type_reg) inside
            brdras_pkg::REQ_LOAD:  bad = (x_reg == '0) || (x_reg > lim);
            brdras_pkg::REQ_ADD,
            brdras_pkg::REQ_QUERY: bad = (x_reg == '0) || (x_reg > y_reg) || (y_reg > lim);
            default:               bad = 1'b1;
        endcase
    end

    // Walker position and block classification
    assign idx_m1  = idx_reg - IW'(1);
    assign x_m1    = x_reg - IW'(1);
    assign y_m1    = y_reg - IW'(1);
    assign cur_blk = idx_m1[AW-1:SH];
    assign bx      = x_m1[AW-1:SH];
    assign by      = y_m1[AW-1:SH];
    assign whole   = (cur_blk != bx) && (cur_blk != by);
    assign idx_next = whole ? idx_reg + IW'(brdras_pkg::BLOCK_SIZE) : idx_reg + IW'(1);

    assign stat.bad       = bad;
    assign stat.walk_done = (type_reg == brdras_pkg::REQ_LOAD) || (idx_reg == y_reg);

    // Second stage: element data back from RAM, block entry update
    assign blk_sum  = sum_reg[s1_blk_reg];
    assign blk_pend = pend_reg[s1_blk_reg];

    always_comb begin
        ram_we   = 1'b0;
        sum_we   = 1'b0;
        pend_we  = 1'b0;
        wr_data  = v_reg;
        sum_new  = blk_sum + v_reg;
        pend_new = blk_pend + v_reg;
        acc_next = acc_reg;
        if (s1_valid_reg) begin
            case (type_reg)
                brdras_pkg::REQ_LOAD: begin
                    ram_we = 1'b1;
                    sum_we = 1'b1;
                end
                brdras_pkg::REQ_ADD: begin
                    if (s1_whole_reg) begin
                        pend_we = 1'b1;
                    end else begin
                        ram_we  = 1'b1;
                        sum_we  = 1'b1;
                        wr_data = rd_data + v_reg;
                    end
                end
                brdras_pkg::REQ_QUERY: begin
                    if (s1_whole_reg) begin
                        acc_next = acc_reg + blk_sum + (blk_pend << SH);
                    end else begin
                        acc_next = acc_reg + rd_data + blk_pend;
                    end
                end
                default: acc_next = acc_reg;
            endcase
        end
    end

    brdras_ram #(
        .WIDTH (DW),
        .DEPTH (brdras_pkg::MAX_ELEMENTS)
    ) u_elem_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (wr_data),
        .raddr (idx_m1[AW-1:0]),
        .rdata (rd_data)
    );

    // Control registers and block tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= brdras_pkg::CNT_RESET;
            s1_valid_reg <= 1'b0;
            for (int b = 0; b < NB; b++) begin
                sum_reg[b]  <= '0;
                pend_reg[b] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                cnt_reg <= cfg_data;
            end
            s1_valid_reg <= cmd.issue;
            if (sum_we) begin
                sum_reg[s1_blk_reg] <= sum_new;
            end
            if (pend_we) begin
                pend_reg[s1_blk_reg] <= pend_new;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg <= brdras_pkg::req_type_t'(s_tuser);
            x_reg    <= s_tdata[IW-1:0];
            y_reg    <= s_tdata[2*IW-1:IW];
            v_reg    <= s_tdata[2*IW+DW-1:2*IW];
            idx_reg  <= s_tdata[IW-1:0];
            acc_reg  <= '0;
        end else begin
            acc_reg <= acc_next;
            if (cmd.issue) begin
                idx_reg <= idx_next;
            end
        end
        if (cmd.issue) begin
            s1_whole_reg <= whole;
            s1_addr_reg  <= idx_m1[AW-1:0];
            s1_blk_reg   <= cur_blk;
        end
        if (cmd.out_load) begin
            out_sum_reg  <= (!bad && type_reg == brdras_pkg::REQ_QUERY) ? acc_reg : '0;
            out_stat_reg <= bad;
        end
    end

    assign m_tdata = out_sum_reg;
    assign m_tuser = out_stat_reg;

endmodule

// File: rtl/block_decomposed_range_add_sum_top.sv
// Range add / range sum engine over fixed blocks of 32 elements.
// Channels: s_ carries one request per item (tuser = request type: 0 load,
// 1 add over range, 2 query sum; tdata = index_from, index_to, value).
// m_ returns one result per request (tdata = range sum, tuser = status,
// 1 for a bad range, bad index or unknown type, with the sum then zero).
// cfg_ writes the element count (1..1024), the highest valid index.
// Timing: one request at a time. An accepted request goes through a check,
// the walk, a drain step and a finish step that loads the output register,
// and only then is the next request taken. The walk has one step per element
// of the two end blocks and one per whole block between them, set by the
// single element RAM read and write port pair. Load is one step, the worst
// range 94 steps; a bad request skips the walk and goes from check to finish.
// The result sits in an output register: a new request is accepted while
// a result waits, and a stalled receiver holds the engine only once that
// next request is ready to report.
// Reset clears block sums, pending adds and the count (back to 1024);
// element storage is not cleared and must be loaded before use.
module block_decomposed_range_add_sum_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index_from [10:0], index_to [21:11], value [85:22], zero fill above
    input  logic [brdras_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type [1:0]
    input  logic [brdras_pkg::TYPE_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // range_sum [63:0]
    output logic [brdras_pkg::DATA_W-1:0]    m_tdata,
    // status [0]
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [brdras_pkg::IDX_W-1:0]     cfg_data
);

    brdras_pkg::dp_cmd_t  cmd;
    brdras_pkg::dp_stat_t stat;

    // Config register is always free to take a write
    assign cfg_ready = 1'b1;

    brdras_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    brdras_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: rtl/brdras_chk.sv
// Port-level checker for the range add / range sum block, bound to the top level.
// Depends on brdras_pkg and the assertion macro header.
`include "block_decomposed_range_add_sum_top_defines.svh"

module brdras_chk (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [brdras_pkg::DATA_W-1:0]    m_tdata,
    input logic                             m_tuser
);

    // A stalled result stays offered
    `BRDRAS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    // One request at a time: busy right after accept
    `BRDRAS_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "accepted twice in a row")
    // A rejected request reports a zero sum
    `BRDRAS_ASSERT_NOW(a_bad_zero, m_tvalid && m_tuser, m_tdata == '0, "bad status with nonzero sum")
    // No result straight out of reset
    `BRDRAS_ASSERT_RST(a_reset_clear, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind block_decomposed_range_add_sum_top brdras_chk u_brdras_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
